// ===== sv/ultrasonic_echo_ranger_top_defines.svh =====
// assertion macros for the ultrasonic echo ranger checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef ULTRASONIC_ECHO_RANGER_TOP_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_TOP_DEFINES_SVH

// same-cycle implication, sampled at the rising clock edge, off during reset
`define UER_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("uer checker: same-cycle property failed");

// next-cycle implication
`define UER_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("uer checker: next-cycle property failed");

`endif

// ===== sv/uer_pkg.sv =====
// shared types, constants and helpers for the ultrasonic echo ranger
// no dependencies
package uer_pkg;

    localparam int COUNT_BITS = 16;
    localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [7:0]  TRIGGER_RESET = 8'd10;
    localparam logic [15:0] RISE_RESET    = 16'd30000;
    localparam logic [15:0] FALL_RESET    = 16'd30000;

    // distance = (width + 29) / 58, done as a multiply by a rounded-up reciprocal
    localparam int DIST_ROUND = 29;
    localparam int DIST_DIV   = 58;
    localparam int DIST_SHIFT = 22;
    localparam int DIST_RECIP = ((1 << DIST_SHIFT) + DIST_DIV - 1) / DIST_DIV;

    typedef enum logic [1:0] {
        REG_TRIGGER = 2'd0,
        REG_RISE    = 2'd1,
        REG_FALL    = 2'd2
    } t_reg_idx;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_TRIG = 4'b0010,
        PH_RISE = 4'b0100,
        PH_MEAS = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0]  trigger_ticks;
        logic [15:0] rise_limit;
        logic [15:0] fall_limit;
    } t_cfg;

    typedef struct packed {
        logic        trigger;
        logic        busy_res;
        logic        done_res;
        logic        timed_out;
        logic [15:0] width_us;
    } t_result;

    // zero acts as one, and a limit never exceeds what the counters hold
    function automatic logic [COUNT_BITS-1:0] eff_limit(input logic [15:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w == 32'd0) begin
            w = 32'd1;
        end
        if (w > COUNT_MAX) begin
            w = COUNT_MAX;
        end
        return COUNT_BITS'(w);
    endfunction

endpackage

// ===== sv/uer_in_if.sv =====
// input channel of the ranger: one tick request with start and echo level
// no dependencies
interface uer_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo;

    modport source (output valid, output start_req, output echo, input ready);
    modport sink   (input valid, input start_req, input echo, output ready);
endinterface

// ===== sv/uer_out_if.sv =====
// result channel of the ranger: one result per tick request
// no dependencies
interface uer_out_if;
    logic        valid;
    logic        ready;
    logic        trigger;
    logic        busy_res;
    logic        done_res;
    logic        timed_out;
    logic [15:0] width_us;
    logic [10:0] distance_cm;

    modport source (output valid, output trigger, output busy_res, output done_res,
                    output timed_out, output width_us, output distance_cm, input ready);
    modport sink   (input valid, input trigger, input busy_res, input done_res,
                    input timed_out, input width_us, input distance_cm, output ready);
endinterface

// ===== sv/uer_core.sv =====
// measurement sequencer: phase, wait counter and high counter, one step per tick
// depends on uer_pkg
module uer_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_start_req,
    input  logic             i_echo,
    input  uer_pkg::t_cfg    i_cfg,
    output uer_pkg::t_result o_res
);
    import uer_pkg::*;

    t_phase                r_phase, n_phase;
    logic [COUNT_BITS-1:0] r_wait, n_wait;
    logic [COUNT_BITS-1:0] r_high, n_high;

    always_comb begin
        logic [COUNT_BITS:0]   wait_inc;
        logic [COUNT_BITS:0]   high_inc;
        logic [COUNT_BITS-1:0] lim_trig;
        logic [COUNT_BITS-1:0] lim_rise;
        logic [COUNT_BITS-1:0] lim_fall;

        lim_trig = eff_limit(16'(i_cfg.trigger_ticks));
        lim_rise = eff_limit(i_cfg.rise_limit);
        lim_fall = eff_limit(i_cfg.fall_limit);

        n_phase = r_phase;
        n_wait  = r_wait;
        n_high  = r_high;
        o_res   = '0;

        // a start while idle enters the trigger phase on this same tick
        if (r_phase == PH_IDLE && i_start_req) begin
            n_phase = PH_TRIG;
            n_wait  = '0;
        end

        wait_inc = {1'b0, n_wait} + (COUNT_BITS+1)'(1);
        high_inc = {1'b0, r_high} + (COUNT_BITS+1)'(1);

        case (n_phase)
            PH_IDLE: begin
                n_phase = PH_IDLE;
            end
            PH_TRIG: begin
                o_res.trigger = 1'b1;
                if (wait_inc >= {1'b0, lim_trig}) begin
                    n_phase = PH_RISE;
                    n_wait  = '0;
                end else begin
                    n_wait = wait_inc[COUNT_BITS-1:0];
                end
            end
            PH_RISE: begin
                if (i_echo) begin
                    n_phase = PH_MEAS;
                    n_high  = COUNT_BITS'(1);
                end else if (wait_inc[COUNT_BITS-1:0] >= lim_rise) begin
                    o_res.timed_out = 1'b1;
                    n_phase = PH_IDLE;
                    n_wait  = '0;
                end else begin
                    n_wait = wait_inc[COUNT_BITS-1:0];
                end
            end
            PH_MEAS: begin
                if (!i_echo) begin
                    o_res.done_res = 1'b1;
                    o_res.width_us = 16'(r_high);
                    n_phase = PH_IDLE;
                end else if (r_high >= lim_fall) begin
                    o_res.timed_out = 1'b1;
                    n_phase = PH_IDLE;
                end else begin
                    n_high = high_inc[COUNT_BITS-1:0];
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        o_res.busy_res = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_wait  <= '0;
            r_high  <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_wait  <= n_wait;
            r_high  <= n_high;
        end
    end

endmodule

// ===== sv/uer_dist58.sv =====
// centimetre conversion: (width + 29) / 58 by reciprocal multiply
// depends on uer_pkg
module uer_dist58 (
    input  logic [15:0] i_width,
    output logic [10:0] o_distance
);
    import uer_pkg::*;

    logic [16:0] sum;
    logic [33:0] prod;

    // reciprocal error stays small enough that the quotient is exact below 2^17
    assign sum        = 17'(i_width) + 17'(DIST_ROUND);
    assign prod       = 34'(sum) * 34'(DIST_RECIP);
    assign o_distance = 11'(prod >> DIST_SHIFT);

endmodule

// ===== sv/ultrasonic_echo_ranger_top.sv =====
// top level of the ultrasonic echo ranger: register port, request and result registers
// depends on uer_pkg, uer_in_if, uer_out_if, uer_core, uer_dist58
//
//   channel   dir   handshake        payload
//   i_in      in    valid/ready      start_req, echo
//   o_out     out   valid/ready      trigger, busy_res, done_res, timed_out,
//                                    width_us, distance_cm
//   apb       in    psel/penable     trigger_ticks @0, rise_limit @4, fall_limit @8
//
// one request per clock unless a result stalls; a request's result is written to the result
// register once it is free (sequencer step and distance multiply between the two registers)
// reset is synchronous on i_rst_n: sequencer idle, both registers empty, registers at defaults
// a stalled result holds in the result register while one more request waits behind it
module ultrasonic_echo_ranger_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    uer_in_if.sink                    i_in,
    uer_out_if.source                 o_out,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [uer_pkg::ADDR_W-1:0] paddr,
    input  logic [uer_pkg::DATA_W-1:0] pwdata,
    output logic [uer_pkg::DATA_W-1:0] prdata,
    output logic                      pready
);
    import uer_pkg::*;

    t_cfg        r_cfg;
    logic        r_in_vld;
    logic        r_start;
    logic        r_echo;
    logic        r_out_vld;
    t_result     r_res;
    logic [10:0] r_dist;

    logic        advance;
    t_result     res;
    logic [10:0] dist_cm;
    t_reg_idx    reg_idx;

    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign pready  = 1'b1;

    always_comb begin
        case (reg_idx)
            REG_TRIGGER: prdata = DATA_W'(r_cfg.trigger_ticks);
            REG_RISE:    prdata = DATA_W'(r_cfg.rise_limit);
            REG_FALL:    prdata = DATA_W'(r_cfg.fall_limit);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_ticks <= TRIGGER_RESET;
            r_cfg.rise_limit    <= RISE_RESET;
            r_cfg.fall_limit    <= FALL_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_TRIGGER: r_cfg.trigger_ticks <= pwdata[7:0];
                REG_RISE:    r_cfg.rise_limit    <= pwdata[15:0];
                REG_FALL:    r_cfg.fall_limit    <= pwdata[15:0];
                default:     r_cfg <= r_cfg;
            endcase
        end
    end

    // a held request moves on when the result register is empty or being drained
    assign advance    = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_start <= i_in.start_req;
            r_echo  <= i_in.echo;
        end
        if (advance) begin
            r_res  <= res;
            r_dist <= dist_cm;
        end
    end

    uer_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_start_req (r_start),
        .i_echo      (r_echo),
        .i_cfg       (r_cfg),
        .o_res       (res)
    );

    uer_dist58 u_dist (
        .i_width    (res.width_us),
        .o_distance (dist_cm)
    );

    assign o_out.valid       = r_out_vld;
    assign o_out.trigger     = r_res.trigger;
    assign o_out.busy_res    = r_res.busy_res;
    assign o_out.done_res    = r_res.done_res;
    assign o_out.timed_out   = r_res.timed_out;
    assign o_out.width_us    = r_res.width_us;
    assign o_out.distance_cm = r_dist;

endmodule

// ===== sv/uer_checker.sv =====
// port-level checks on the ranger results, bound to the top level
// depends on ultrasonic_echo_ranger_top_defines.svh and ultrasonic_echo_ranger_top
`include "ultrasonic_echo_ranger_top_defines.svh"

module uer_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_trigger,
    input logic        i_busy_res,
    input logic        i_done_res,
    input logic        i_timed_out,
    input logic [15:0] i_width_us,
    input logic [10:0] i_distance_cm
);

    // a completed or abandoned measurement leaves the block idle
    `UER_ASSERT_NOW(a_done_idle, i_valid && i_done_res, !i_busy_res && !i_timed_out && !i_trigger)
    `UER_ASSERT_NOW(a_tmo_idle, i_valid && i_timed_out, !i_busy_res && !i_done_res)
    // measured values only show on a completion
    `UER_ASSERT_NOW(a_vals_zero, i_valid && !i_done_res, i_width_us == 16'd0 && i_distance_cm == 11'd0)
    // trigger is only driven inside a measurement
    `UER_ASSERT_NOW(a_trig_busy, i_valid && i_trigger, i_busy_res)
    // a stalled result holds
    `UER_ASSERT_NEXT(a_stall_hold, i_valid && !i_ready, i_valid && $stable(i_width_us) && $stable(i_done_res))

endmodule

bind ultrasonic_echo_ranger_top uer_checker u_uer_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_out.valid),
    .i_ready       (o_out.ready),
    .i_trigger     (o_out.trigger),
    .i_busy_res    (o_out.busy_res),
    .i_done_res    (o_out.done_res),
    .i_timed_out   (o_out.timed_out),
    .i_width_us    (o_out.width_us),
    .i_distance_cm (o_out.distance_cm)
);
